/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked implication checks with an active-low reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");

// next-cycle implication
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`endif

/* design/dfm_pkg.sv */
// ----------------------------------------------------------------------------
// dfm_pkg
// Shared constants, payload types and control structs of the falloff stamp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dfm_pkg;

	localparam int GRID_BITS  = 7;
	localparam int GRID_SIZE  = 1 << GRID_BITS;
	localparam int ADDR_W     = 2 * GRID_BITS;
	localparam int GRID_CELLS = GRID_SIZE * GRID_SIZE;
	localparam int MAX_RADIUS = 31;
	localparam int RAD_W      = 5;
	localparam int COV_W      = 8;
	localparam int SIZE_W     = 8;
	localparam int OFS_W      = RAD_W + 1;
	localparam int NUM_W      = 14;
	localparam int DEN_W      = RAD_W + 1;
	localparam int DCNT_W     = 4;
	localparam int CFG_IDX_W  = 2;

	localparam logic [1:0] MODE_CLEAR = 2'd0;
	localparam logic [1:0] MODE_STAMP = 2'd1;
	localparam logic [1:0] MODE_READ  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 2'd1;

	localparam logic [SIZE_W-1:0] MAP_SIZE_RESET = 8'd128;

	typedef struct packed {
		logic [1:0]           mode;
		logic [GRID_BITS-1:0] pos_x;
		logic [GRID_BITS-1:0] pos_y;
		logic [RAD_W-1:0]     radius;
		logic [COV_W-1:0]     strength;
		logic                 active;
	} req_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic [COV_W-1:0] coverage;
	} rsp_t;

	typedef struct packed {
		logic latch;
		logic sweep_wr;
		logic div_go;
		logic tab_wr;
		logic scan_step;
		logic rd_item;
	} dp_cmd_t;

	typedef struct packed {
		logic sweep_last;
		logic div_done;
		logic k_last;
		logic scan_last;
	} dp_stat_t;

endpackage

/* design/dfm_div.sv */
// ----------------------------------------------------------------------------
// dfm_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dfm_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      go,
	input  logic [dfm_pkg::NUM_W-1:0] num,
	input  logic [dfm_pkg::DEN_W-1:0] den,
	output logic                      done,
	output logic [dfm_pkg::COV_W-1:0] quo
);

	logic                        run_q;
	logic                        done_q;
	logic [dfm_pkg::DCNT_W-1:0]  cnt_q;
	logic [dfm_pkg::DEN_W-1:0]   den_q;
	logic [dfm_pkg::DEN_W-1:0]   rem_q;
	logic [dfm_pkg::NUM_W-1:0]   quo_q;
	logic [dfm_pkg::DEN_W:0]     sh;
	logic [dfm_pkg::DEN_W:0]     diff;
	logic                        ge;

	localparam logic [dfm_pkg::DCNT_W-1:0] LAST_CNT = dfm_pkg::DCNT_W'(dfm_pkg::NUM_W - 1);

	assign sh   = {rem_q, quo_q[dfm_pkg::NUM_W-1]};
	assign ge   = sh >= {1'b0, den_q};
	assign diff = sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_CNT) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			den_q <= den;
			rem_q <= '0;
			quo_q <= num;
		end else if (run_q) begin
			rem_q <= ge ? diff[dfm_pkg::DEN_W-1:0] : sh[dfm_pkg::DEN_W-1:0];
			quo_q <= {quo_q[dfm_pkg::NUM_W-2:0], ge};
		end
	end

	// quotient never exceeds the strength, so the low byte holds it all
	assign done = done_q;
	assign quo  = quo_q[dfm_pkg::COV_W-1:0];

endmodule

/* design/dfm_ctrl.sv */
// ----------------------------------------------------------------------------
// dfm_ctrl
// Sequencer: reset clearing pass, clear sweep, table build, tile scan, read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dfm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  dfm_pkg::req_t     req,
	input  dfm_pkg::dp_stat_t stat,
	output dfm_pkg::dp_cmd_t  cmd,
	output logic              busy,
	output logic              done
);

	typedef enum logic [8:0] {
		S_INIT   = 9'b000000001,
		S_IDLE   = 9'b000000010,
		S_CLEAR  = 9'b000000100,
		S_DSTART = 9'b000001000,
		S_DWAIT  = 9'b000010000,
		S_SCAN   = 9'b000100000,
		S_DRAIN  = 9'b001000000,
		S_READ   = 9'b010000000,
		S_RESP   = 9'b100000000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_INIT: begin
				cmd.sweep_wr = 1'b1;
				if (stat.sweep_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					priority if (req.mode == dfm_pkg::MODE_CLEAR) begin
						state_d = S_CLEAR;
					end else if (req.mode == dfm_pkg::MODE_STAMP) begin
						state_d = (req.active && req.radius != '0) ? S_DSTART : S_RESP;
					end else if (req.mode == dfm_pkg::MODE_READ) begin
						state_d = S_READ;
					end else begin
						state_d = S_RESP;
					end
				end
			end
			S_CLEAR: begin
				cmd.sweep_wr = 1'b1;
				if (stat.sweep_last) state_d = S_RESP;
			end
			S_DSTART: begin
				cmd.div_go = 1'b1;
				state_d    = S_DWAIT;
			end
			S_DWAIT: begin
				if (stat.div_done) begin
					cmd.tab_wr = 1'b1;
					state_d    = stat.k_last ? S_SCAN : S_DSTART;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_last) state_d = S_DRAIN;
			end
			S_DRAIN: state_d = S_RESP;
			S_READ: begin
				cmd.rd_item = 1'b1;
				state_d     = S_RESP;
			end
			S_RESP: state_d = S_IDLE;
			default: state_d = S_INIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = state_q != S_IDLE;
	assign done = state_q == S_RESP;

endmodule

/* design/dfm_dp.sv */
// ----------------------------------------------------------------------------
// dfm_dp
// Datapath: grid memory, map registers, falloff table, scan counters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dfm_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dfm_pkg::req_t                 req,
	input  dfm_pkg::dp_cmd_t              cmd,
	input  logic                          cfg_we,
	input  logic [dfm_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [dfm_pkg::SIZE_W-1:0]    cfg_wdata,
	output dfm_pkg::dp_stat_t             stat,
	output dfm_pkg::rsp_t                 rsp
);

	localparam logic [dfm_pkg::SIZE_W-1:0] GRID_LIM = dfm_pkg::SIZE_W'(dfm_pkg::GRID_SIZE);
	localparam int YW = dfm_pkg::GRID_BITS + 2;

	// grid store
	logic [dfm_pkg::COV_W-1:0]  mem [dfm_pkg::GRID_CELLS];
	logic [dfm_pkg::COV_W-1:0]  rd_q;
	logic [dfm_pkg::ADDR_W-1:0] rd_addr;
	logic [dfm_pkg::ADDR_W-1:0] wr_addr;
	logic [dfm_pkg::COV_W-1:0]  wr_data;
	logic                       wr_en;

	logic [dfm_pkg::SIZE_W-1:0] map_w_q;
	logic [dfm_pkg::SIZE_W-1:0] map_h_q;
	logic [dfm_pkg::SIZE_W-1:0] w_use;
	logic [dfm_pkg::SIZE_W-1:0] h_use;

	logic [dfm_pkg::ADDR_W-1:0] sweep_q;

	// latched item
	logic [1:0]                    mode_q;
	logic [dfm_pkg::GRID_BITS-1:0] cx_q;
	logic [dfm_pkg::GRID_BITS-1:0] cy_q;
	logic [dfm_pkg::RAD_W-1:0]     r_q;
	logic [dfm_pkg::COV_W-1:0]     s_q;
	logic                          inmap_q;

	// falloff table, entry k-1 holds the value at r-d = k
	logic [dfm_pkg::COV_W-1:0] tab_q [dfm_pkg::MAX_RADIUS];
	logic [dfm_pkg::RAD_W-1:0] k_q;
	logic [dfm_pkg::NUM_W-1:0] num;
	logic [dfm_pkg::NUM_W-1:0] prod;
	logic                      div_done;
	logic [dfm_pkg::COV_W-1:0] div_quo;

	// scan
	logic [dfm_pkg::OFS_W-1:0]  dx_q;
	logic [dfm_pkg::OFS_W-1:0]  dy_q;
	logic [dfm_pkg::OFS_W-1:0]  rm1;
	logic [dfm_pkg::OFS_W-1:0]  rm1_req;
	logic [YW-1:0]              tx;
	logic [YW-1:0]              ty;
	logic [dfm_pkg::OFS_W-1:0]  adx;
	logic [dfm_pkg::OFS_W-1:0]  ady;
	logic [dfm_pkg::OFS_W-1:0]  tile_d;
	logic [dfm_pkg::OFS_W-1:0]  tidx;
	logic                       hit;
	logic [dfm_pkg::ADDR_W-1:0] addr_s1;
	logic [dfm_pkg::COV_W-1:0]  v_s1;
	logic                       en_s1;

	assign w_use = (map_w_q > GRID_LIM) ? GRID_LIM : map_w_q;
	assign h_use = (map_h_q > GRID_LIM) ? GRID_LIM : map_h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_w_q <= dfm_pkg::MAP_SIZE_RESET;
			map_h_q <= dfm_pkg::MAP_SIZE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				dfm_pkg::CFG_MAP_WIDTH:  map_w_q <= cfg_wdata;
				dfm_pkg::CFG_MAP_HEIGHT: map_h_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// sweep wraps to zero after the last cell, ready for the next pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
		end else if (cmd.sweep_wr) begin
			sweep_q <= sweep_q + 1'b1;
		end
	end

	assign rm1_req = {1'b0, req.radius} - 1'b1;
	assign rm1     = {1'b0, r_q} - 1'b1;

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			mode_q  <= req.mode;
			cx_q    <= req.pos_x;
			cy_q    <= req.pos_y;
			r_q     <= req.radius;
			s_q     <= req.strength;
			inmap_q <= ({1'b0, req.pos_x} < w_use) && ({1'b0, req.pos_y} < h_use);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q  <= '0;
			dx_q <= '0;
			dy_q <= '0;
		end else if (cmd.latch) begin
			k_q  <= dfm_pkg::RAD_W'(1);
			dx_q <= '0 - rm1_req;
			dy_q <= '0 - rm1_req;
		end else begin
			if (cmd.tab_wr) k_q <= k_q + 1'b1;
			if (cmd.scan_step) begin
				if (dx_q == rm1) begin
					dx_q <= '0 - rm1;
					dy_q <= dy_q + 1'b1;
				end else begin
					dx_q <= dx_q + 1'b1;
				end
			end
		end
	end

	// numerator 2*s*k + r of the half-up rounding, divided by 2*r
	assign prod = dfm_pkg::NUM_W'(s_q) * dfm_pkg::NUM_W'(k_q);
	assign num  = {prod[dfm_pkg::NUM_W-2:0], 1'b0} + dfm_pkg::NUM_W'(r_q);

	dfm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (cmd.div_go),
		.num    (num),
		.den    ({r_q, 1'b0}),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk) begin
		if (cmd.tab_wr) tab_q[k_q - 1'b1] <= div_quo;
	end

	// tile under the scan counters; offsets stay within +/-30 so bit 8 is the sign
	assign tx     = {2'b00, cx_q} + {{(YW-dfm_pkg::OFS_W){dx_q[dfm_pkg::OFS_W-1]}}, dx_q};
	assign ty     = {2'b00, cy_q} + {{(YW-dfm_pkg::OFS_W){dy_q[dfm_pkg::OFS_W-1]}}, dy_q};
	assign adx    = dx_q[dfm_pkg::OFS_W-1] ? ('0 - dx_q) : dx_q;
	assign ady    = dy_q[dfm_pkg::OFS_W-1] ? ('0 - dy_q) : dy_q;
	assign tile_d = adx + ady;
	assign tidx   = rm1 - tile_d;
	assign hit    = !tx[YW-1] && (tx[YW-2:0] < w_use) &&
	                !ty[YW-1] && (ty[YW-2:0] < h_use) &&
	                (tile_d < {1'b0, r_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_s1 <= 1'b0;
		end else begin
			en_s1 <= cmd.scan_step && hit;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= {ty[dfm_pkg::GRID_BITS-1:0], tx[dfm_pkg::GRID_BITS-1:0]};
		v_s1    <= tab_q[tidx[dfm_pkg::RAD_W-1:0]];
	end

	assign rd_addr = cmd.rd_item ? {cy_q, cx_q}
	                             : {ty[dfm_pkg::GRID_BITS-1:0], tx[dfm_pkg::GRID_BITS-1:0]};
	assign wr_en   = cmd.sweep_wr || (en_s1 && (v_s1 > rd_q));
	assign wr_addr = cmd.sweep_wr ? sweep_q : addr_s1;
	assign wr_data = cmd.sweep_wr ? '0 : v_s1;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_q <= mem[rd_addr];
	end

	assign stat.sweep_last = sweep_q == '1;
	assign stat.div_done   = div_done;
	assign stat.k_last     = k_q == r_q;
	assign stat.scan_last  = (dx_q == rm1) && (dy_q == rm1);

	assign rsp.kind     = mode_q;
	assign rsp.coverage = (mode_q == dfm_pkg::MODE_READ && inmap_q) ? rd_q : '0;

endmodule

/* design/diamond_falloff_max_stamp.sv */
// ----------------------------------------------------------------------------
// diamond_falloff_max_stamp
// 128x128 coverage grid with clear, diamond falloff max stamp and tile read.
// ----------------------------------------------------------------------------
// Usage:
//   An item (req) is taken on a rising edge with start high and busy low.
//   Every item gives exactly one result: result is valid while done is high,
//   for one cycle, and the receiver has no way to hold it off.
//   The user writes map_width / map_height through cfg_we, cfg_idx, cfg_wdata
//   only while the block is idle (unenforced); other indexes are ignored.
// Operations (from transfer to done):
//   clear           one grid cell zeroed per cycle
//   stamp           the falloff table is built by a one-bit-per-cycle
//                   divider, one entry at a time, then the diamond's
//                   bounding square is scanned one tile per cycle through
//                   the single read and write port of the grid
//   inactive stamp, radius zero, unused mode: result only, no grid access
//   read            one registered memory read
// busy stays high until the cycle after done, so items run one at a time.
// Reset: a clearing pass zeroes the grid, with busy high; configuration
// writes are taken during it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module diamond_falloff_max_stamp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  dfm_pkg::req_t                 req,
	output logic                          busy,
	output logic                          done,
	output dfm_pkg::rsp_t                 result,
	input  logic                          cfg_we,
	input  logic [dfm_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [dfm_pkg::SIZE_W-1:0]    cfg_wdata
);

	dfm_pkg::dp_cmd_t  cmd;
	dfm_pkg::dp_stat_t stat;

	dfm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	dfm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.stat      (stat),
		.rsp       (result)
	);

endmodule

/* design/dfm_chk.sv */
// ----------------------------------------------------------------------------
// dfm_chk
// Port-level checks on the command and result channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dfm_chk (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input logic          done,
	input dfm_pkg::rsp_t result
);

	logic not_read;

	assign not_read = result.kind != dfm_pkg::MODE_READ;

	// results only come from an item in flight
	`ASSERT_IMP(a_done_busy, clk, arst_n, done, busy)
	// a result is shown for a single cycle
	`ASSERT_NXT(a_done_pulse, clk, arst_n, done, !done)
	// a transfer makes the block busy at once
	`ASSERT_NXT(a_take_busy, clk, arst_n, start && !busy, busy)
	// only reads carry coverage
	`ASSERT_IMP(a_cov_zero, clk, arst_n, done && not_read, result.coverage == '0)

endmodule

bind diamond_falloff_max_stamp dfm_chk u_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
